// File: hw/rtl/swoi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swoi_pkg
// shared types and constants for the argsort insertion chain
// ----------------------------------------------------------------------------
package swoi_pkg;

    localparam int SWOI_MAX_ITEMS = 64;
    localparam int VALUE_W        = 32;
    localparam int INDEX_W        = 6;

    // payload held by one cell
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } data_t;

    // cell contents with occupancy flag
    typedef struct packed {
        logic  valid;
        data_t data;
    } entry_t;

    // chain-wide control
    typedef struct packed {
        logic insert;
        logic shift_out;
    } ctrl_t;

endpackage

// File: hw/rtl/swoi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swoi_cell
// one insertion cell: keeps its slot of the sorted set, takes the new value,
// its left neighbor's entry or its right neighbor's entry
// ----------------------------------------------------------------------------
module swoi_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  swoi_pkg::ctrl_t ctrl,
    input  swoi_pkg::data_t new_item,
    input  swoi_pkg::entry_t left_entry,
    input  logic            left_greater,
    input  swoi_pkg::entry_t right_entry,
    output swoi_pkg::entry_t entry,
    output logic            greater
);
    import swoi_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    data_t data_reg;
    data_t data_next;

    // empty slot counts as larger than anything; ties keep the older entry
    assign greater = !valid_reg || ($signed(data_reg.value) > $signed(new_item.value));

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

    // next contents
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctrl.shift_out)
        begin
            valid_next = right_entry.valid;
            data_next  = right_entry.data;
        end
        else if (ctrl.insert && greater)
        begin
            if (left_greater)
            begin
                valid_next = left_entry.valid;
                data_next  = left_entry.data;
            end
            else
            begin
                valid_next = 1'b1;
                data_next  = new_item;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: hw/rtl/sort_with_original_index_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_with_original_index_unit
// argsort of signed 32-bit values through a chain of insertion cells
// ----------------------------------------------------------------------------
// Values stream in at one transfer per cycle; each one is placed in its sorted
// slot of a chain of MAX_ITEMS insertion cells in the cycle it arrives. The
// transfer with last_item closes the set: from the next cycle on, results
// leave the head of the chain one per cycle unless result_stall is set
// (ascending signed value, ties by ascending arrival index), and input stays
// stalled until the result marked final_result has been taken. Values beyond
// MAX_ITEMS are dropped and every result of that set carries overflow.
module sort_with_original_index_unit #(
    parameter int MAX_ITEMS = swoi_pkg::SWOI_MAX_ITEMS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [swoi_pkg::VALUE_W-1:0]  value,
    input  logic                                 last_item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [swoi_pkg::VALUE_W-1:0]  sorted_value,
    output logic [swoi_pkg::INDEX_W-1:0]         original_index,
    output logic                                 final_result,
    output logic                                 overflow
);
    import swoi_pkg::*;

    localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_ITEMS);

    logic               unload_reg;
    logic               unload_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               overflow_reg;
    logic               overflow_next;

    logic   item_xfer;
    logic   result_xfer;
    logic   room;
    ctrl_t  ctrl;
    data_t  new_item;
    entry_t cell_entry [MAX_ITEMS];
    logic   cell_greater [MAX_ITEMS];

    // handshakes
    assign item_stall  = unload_reg;
    assign item_xfer   = item_valid && !item_stall;
    assign result_valid = unload_reg;
    assign result_xfer = result_valid && !result_stall;
    assign room        = count_reg < COUNT_MAX;

    // chain control and incoming entry
    assign ctrl.insert    = item_xfer && room;
    assign ctrl.shift_out = result_xfer;
    assign new_item.value = value;
    assign new_item.index = INDEX_W'(count_reg);

    // insertion chain
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        entry_t left_e;
        logic   left_g;
        entry_t right_e;

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_g = cell_greater[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        swoi_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .new_item     (new_item),
            .left_entry   (left_e),
            .left_greater (left_g),
            .right_entry  (right_e),
            .entry        (cell_entry[i]),
            .greater      (cell_greater[i])
        );
    end

    // result fields from the head cell
    assign sorted_value   = cell_entry[0].data.value;
    assign original_index = cell_entry[0].data.index;
    assign final_result   = !cell_entry[1].valid;
    assign overflow       = overflow_reg;

    // load / unload sequencing
    always_comb
    begin
        unload_next   = unload_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        priority if (result_xfer && final_result)
        begin
            unload_next   = 1'b0;
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (item_xfer)
        begin
            if (room)
                count_next = count_reg + COUNT_W'(1);
            else
                overflow_next = 1'b1;
            if (last_item)
                unload_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unload_reg   <= 1'b0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            unload_reg   <= unload_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // checks
    a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> cell_entry[0].valid)
        else $error("result offered from an empty head cell");

    a_final_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (result_xfer && final_result) |=> (!result_valid && count_reg == '0))
        else $error("unload did not end after final transfer");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("item count beyond chain length");

    a_overflow_full : assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (count_reg == COUNT_MAX))
        else $error("overflow flagged while chain not full");

endmodule
